// ----- src/hcrc_pkg.sv -----
// Shared types and constants for the halo corner region classifier.
// Used by the channel interfaces, the classify logic and the top level.
// No dependencies.
package hcrc_pkg;

  // Default coordinate format.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int SIZE_W   = 31;
  localparam int MASK_W   = 6;
  localparam int REGION_W = 3;
  localparam int CFG_IDX_W = 2;

  // Cell sizes reset to 1.0 in the default format.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536;

  // Halo mask bit positions.
  localparam int MASK_NORTH = 0;
  localparam int MASK_SOUTH = 1;
  localparam int MASK_EAST  = 2;
  localparam int MASK_WEST  = 3;
  localparam int MASK_ABOVE = 4;
  localparam int MASK_BELOW = 5;

  // Face codes reported in the result.
  typedef enum logic [REGION_W-1:0] {
    REGION_NORTH = 3'd0,
    REGION_SOUTH = 3'd1,
    REGION_EAST  = 3'd2,
    REGION_WEST  = 3'd3,
    REGION_ABOVE = 3'd4,
    REGION_BELOW = 3'd5
  } region_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  // Cell extent registers.
  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cfg_t;

  // One classification result.
  typedef struct packed {
    region_e region;
    logic    fallback_used;
    logic    outside_cell;
  } result_t;

endpackage

// ----- src/hcrc_in_if.sv -----
// Input channel interface: particle position, cell origin and halo mask.
// Depends on hcrc_pkg for the mask width.
interface hcrc_in_if #(
  parameter int COORD_WIDTH = hcrc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] particle_x;
  logic signed [COORD_WIDTH-1:0] particle_y;
  logic signed [COORD_WIDTH-1:0] particle_z;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic [hcrc_pkg::MASK_W-1:0]   halo_mask;

  modport source (
    output valid, particle_x, particle_y, particle_z,
    output origin_x, origin_y, origin_z, halo_mask,
    input  ready
  );

  modport sink (
    input  valid, particle_x, particle_y, particle_z,
    input  origin_x, origin_y, origin_z, halo_mask,
    output ready
  );
endinterface

// ----- src/hcrc_out_if.sv -----
// Output channel interface: chosen face and the two status flags.
// Depends on hcrc_pkg for the region width.
interface hcrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [hcrc_pkg::REGION_W-1:0] region;
  logic                          fallback_used;
  logic                          outside_cell;

  modport source (
    output valid, region, fallback_used, outside_cell,
    input  ready
  );

  modport sink (
    input  valid, region, fallback_used, outside_cell,
    output ready
  );
endinterface

// ----- src/hcrc_classify.sv -----
// Combinational classification of one registered item into a halo face.
// Depends on hcrc_pkg for the configuration and result types.
module hcrc_classify #(
  parameter int COORD_WIDTH = hcrc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = hcrc_pkg::FRAC_BITS_DEF
) (
  input  logic signed [COORD_WIDTH-1:0] particle_x_i,
  input  logic signed [COORD_WIDTH-1:0] particle_y_i,
  input  logic signed [COORD_WIDTH-1:0] particle_z_i,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic [hcrc_pkg::MASK_W-1:0]   halo_mask_i,
  input  hcrc_pkg::cfg_t                cfg_i,
  output hcrc_pkg::result_t             result_o
);

  // Coordinates are taken over at most 48 low bits.
  localparam int CW   = (COORD_WIDTH > 48) ? 48 : COORD_WIDTH;
  // Width for compares against the 31-bit cell sizes.
  localparam int CMPW = (CW + 1 > 32) ? CW + 1 : 32;
  // Width for the doubled plane sums, large enough to hold 2.0 as well.
  localparam int SW   = (CW + 4 > FRAC_BITS + 3) ? CW + 4 : FRAC_BITS + 3;

  logic signed [CW:0]     rel_x, rel_y, rel_z, diff_z;
  logic signed [CMPW-1:0] cmp_x, cmp_y, cmp_z;
  logic signed [CMPW-1:0] lim_x, lim_y, lim_z;
  logic signed [SW-1:0]   xs, ys2, zs, one_s, two_s;
  logic signed [SW-1:0]   sum_pxmz, sum_nxmz, sum_nxpz, sum_pxpz;
  logic                   three_d, outside;
  logic [2:0]             face_cnt;
  logic                   n, s, e, w, a, b;
  logic                   x_le_y, x_gt_z, z_le_y;
  hcrc_pkg::region_e      region;
  logic                   hit;

  // Relative position; z is zero for a two-dimensional cell.
  assign three_d = (cfg_i.size_z != '0);
  assign rel_x  = {particle_x_i[CW-1], particle_x_i[CW-1:0]}
                - {origin_x_i[CW-1], origin_x_i[CW-1:0]};
  assign rel_y  = {particle_y_i[CW-1], particle_y_i[CW-1:0]}
                - {origin_y_i[CW-1], origin_y_i[CW-1:0]};
  assign diff_z = {particle_z_i[CW-1], particle_z_i[CW-1:0]}
                - {origin_z_i[CW-1], origin_z_i[CW-1:0]};
  assign rel_z  = three_d ? diff_z : '0;

  // Bounds check against the cell extent.
  assign cmp_x = CMPW'(rel_x);
  assign cmp_y = CMPW'(rel_y);
  assign cmp_z = CMPW'(rel_z);
  assign lim_x = CMPW'(signed'({1'b0, cfg_i.size_x}));
  assign lim_y = CMPW'(signed'({1'b0, cfg_i.size_y}));
  assign lim_z = CMPW'(signed'({1'b0, cfg_i.size_z}));
  assign outside = cmp_x < 0 || cmp_x > lim_x || cmp_y < 0 || cmp_y > lim_y
                || (three_d && (cmp_z < 0 || cmp_z > lim_z));

  // Face bits and their count.
  assign n = halo_mask_i[hcrc_pkg::MASK_NORTH];
  assign s = halo_mask_i[hcrc_pkg::MASK_SOUTH];
  assign e = halo_mask_i[hcrc_pkg::MASK_EAST];
  assign w = halo_mask_i[hcrc_pkg::MASK_WEST];
  assign a = halo_mask_i[hcrc_pkg::MASK_ABOVE];
  assign b = halo_mask_i[hcrc_pkg::MASK_BELOW];
  assign face_cnt = 3'(n) + 3'(s) + 3'(e) + 3'(w) + 3'(a) + 3'(b);

  // Diagonal compares.
  assign x_le_y = rel_x <= rel_y;
  assign x_gt_z = rel_x > rel_z;
  assign z_le_y = rel_z <= rel_y;

  // Doubled plane sums for the triple-corner tests.
  assign xs    = SW'(rel_x);
  assign zs    = SW'(rel_z);
  assign ys2   = SW'(rel_y) <<< 1;
  assign one_s = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS;
  assign two_s = one_s << 1;
  assign sum_pxmz = xs - zs + ys2;
  assign sum_nxmz = -xs - zs + ys2;
  assign sum_nxpz = -xs + zs + ys2;
  assign sum_pxpz = xs + zs + ys2;

  // Face selection in priority order.
  always_comb begin
    region = hcrc_pkg::REGION_NORTH;
    hit    = 1'b1;
    if (!three_d || face_cnt == 3'd2) begin
      // Corner or edge: pick by the diagonal of the two face axes.
      if (n && e) begin
        region = x_le_y ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_EAST;
      end else if (s && w) begin
        region = x_le_y ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_SOUTH;
      end else if (n && w) begin
        region = !x_le_y ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_WEST;
      end else if (s && e) begin
        region = !x_le_y ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_SOUTH;
      end else if (three_d && b && w) begin
        region = !x_gt_z ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_BELOW;
      end else if (three_d && a && e) begin
        region = !x_gt_z ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_EAST;
      end else if (three_d && b && e) begin
        region = x_gt_z ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_BELOW;
      end else if (three_d && a && w) begin
        region = x_gt_z ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_WEST;
      end else if (three_d && b && s) begin
        region = z_le_y ? hcrc_pkg::REGION_BELOW : hcrc_pkg::REGION_SOUTH;
      end else if (three_d && a && n) begin
        region = z_le_y ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_ABOVE;
      end else if (three_d && b && n) begin
        region = !z_le_y ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_BELOW;
      end else if (three_d && a && s) begin
        region = !z_le_y ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_SOUTH;
      end else begin
        hit = 1'b0;
      end
    end else begin
      // Triple corner: plane test first, then the x/z diagonal.
      if (b && s && e) begin
        region = (sum_pxmz >= one_s)
               ? (x_gt_z ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_BELOW)
               : hcrc_pkg::REGION_SOUTH;
      end else if (b && s && w) begin
        region = (sum_nxmz >= 0)
               ? (!x_gt_z ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_BELOW)
               : hcrc_pkg::REGION_SOUTH;
      end else if (b && n && e) begin
        region = (sum_nxpz >= one_s) ? hcrc_pkg::REGION_NORTH
               : (x_gt_z ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_BELOW);
      end else if (b && n && w) begin
        region = (sum_pxpz >= two_s) ? hcrc_pkg::REGION_NORTH
               : (!x_gt_z ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_BELOW);
      end else if (a && s && e) begin
        region = (sum_pxpz >= two_s)
               ? (!x_gt_z ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_EAST)
               : hcrc_pkg::REGION_SOUTH;
      end else if (a && s && w) begin
        region = (sum_nxpz >= one_s)
               ? (x_gt_z ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_WEST)
               : hcrc_pkg::REGION_SOUTH;
      end else if (a && n && e) begin
        region = (sum_nxmz >= 0) ? hcrc_pkg::REGION_NORTH
               : (!x_gt_z ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_EAST);
      end else if (a && n && w) begin
        region = (sum_pxmz >= one_s) ? hcrc_pkg::REGION_NORTH
               : (x_gt_z ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_WEST);
      end else begin
        hit = 1'b0;
      end
    end
  end

  assign result_o.region        = hit ? region : hcrc_pkg::REGION_NORTH;
  assign result_o.fallback_used = !hit;
  assign result_o.outside_cell  = outside;

endmodule

// ----- src/halo_corner_region_classify_top.sv -----
// Structure: an input register and a result register, with the classify logic between them.
// Throughput: one transaction per cycle; with both registers full, input ready follows output ready.
// The rate is set by the single pass of subtract, compare and select logic between them.
// Reset clears both valid flags and sets all three cell sizes to 1.0.
// Depends on hcrc_pkg, hcrc_in_if, hcrc_out_if and hcrc_classify.
module halo_corner_region_classify_top #(
  parameter int COORD_WIDTH = hcrc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = hcrc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hcrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hcrc_pkg::SIZE_W-1:0]    cfg_data_i,
  hcrc_in_if.sink                        in_i,
  hcrc_out_if.source                     out_o
);

  hcrc_pkg::cfg_t                cfg_q;
  logic                          in_valid_q;
  logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q, ox_q, oy_q, oz_q;
  logic [hcrc_pkg::MASK_W-1:0]   mask_q;
  logic                          out_valid_q;
  hcrc_pkg::result_t             res_d, res_q;
  logic                          out_adv;
  logic                          in_take;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x <= hcrc_pkg::SIZE_RESET;
      cfg_q.size_y <= hcrc_pkg::SIZE_RESET;
      cfg_q.size_z <= hcrc_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hcrc_pkg::CFG_SIZE_X: cfg_q.size_x <= cfg_data_i;
        hcrc_pkg::CFG_SIZE_Y: cfg_q.size_y <= cfg_data_i;
        hcrc_pkg::CFG_SIZE_Z: cfg_q.size_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the result register moves when empty or taken downstream.
  assign out_adv    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || out_adv;
  assign in_take    = in_i.valid && in_i.ready;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      px_q   <= in_i.particle_x;
      py_q   <= in_i.particle_y;
      pz_q   <= in_i.particle_z;
      ox_q   <= in_i.origin_x;
      oy_q   <= in_i.origin_y;
      oz_q   <= in_i.origin_z;
      mask_q <= in_i.halo_mask;
    end
  end

  hcrc_classify #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_classify (
    .particle_x_i (px_q),
    .particle_y_i (py_q),
    .particle_z_i (pz_q),
    .origin_x_i   (ox_q),
    .origin_y_i   (oy_q),
    .origin_z_i   (oz_q),
    .halo_mask_i  (mask_q),
    .cfg_i        (cfg_q),
    .result_o     (res_d)
  );

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.region        = res_q.region;
  assign out_o.fallback_used = res_q.fallback_used;
  assign out_o.outside_cell  = res_q.outside_cell;

`ifndef SYNTHESIS
  // A fallback result always reports north.
  a_fallback_north: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.fallback_used |-> res_q.region == hcrc_pkg::REGION_NORTH)
    else $error("fallback result does not report north");

  // A valid result names one of the six faces.
  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.region <= hcrc_pkg::REGION_BELOW)
    else $error("result region out of range");

  // An item in the input register moves to the result register when it is free.
  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_adv |=> out_valid_q)
    else $error("item lost between input and result registers");

  // The input side stalls only when both registers are full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a blocked pipeline");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for halo_corner_region_classify_top: directed and random
// transactions are checked against a behavioral classifier kept in this file.
// Depends on hcrc_pkg, hcrc_in_if, hcrc_out_if and the top level of the block.
module tb;

  localparam longint UNIT    = longint'(1) <<< hcrc_pkg::FRAC_BITS_DEF;
  localparam longint QUARTER = UNIT / 4;

  localparam logic [hcrc_pkg::SIZE_W-1:0] SIZE_MAX  = '1;
  localparam logic [hcrc_pkg::SIZE_W-1:0] SIZE_ONE  = hcrc_pkg::SIZE_W'(UNIT);
  localparam logic [hcrc_pkg::SIZE_W-1:0] SIZE_ZERO = '0;

  // Single-face mask values built from the package bit positions.
  localparam logic [hcrc_pkg::MASK_W-1:0] FACE_N = hcrc_pkg::MASK_W'(1) << hcrc_pkg::MASK_NORTH;
  localparam logic [hcrc_pkg::MASK_W-1:0] FACE_S = hcrc_pkg::MASK_W'(1) << hcrc_pkg::MASK_SOUTH;
  localparam logic [hcrc_pkg::MASK_W-1:0] FACE_E = hcrc_pkg::MASK_W'(1) << hcrc_pkg::MASK_EAST;
  localparam logic [hcrc_pkg::MASK_W-1:0] FACE_W = hcrc_pkg::MASK_W'(1) << hcrc_pkg::MASK_WEST;
  localparam logic [hcrc_pkg::MASK_W-1:0] FACE_A = hcrc_pkg::MASK_W'(1) << hcrc_pkg::MASK_ABOVE;
  localparam logic [hcrc_pkg::MASK_W-1:0] FACE_B = hcrc_pkg::MASK_W'(1) << hcrc_pkg::MASK_BELOW;

  // Cell origin used by the directed transactions.
  localparam longint DIR_ORG_X = 5 * UNIT + 17;
  localparam longint DIR_ORG_Y = -7 * UNIT;
  localparam longint DIR_ORG_Z = 2 * UNIT - 3;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int DRAIN_CYCLES    = 4;
  localparam int MAX_REPORTS     = 10;

  localparam int unsigned SEND_IDLE[4]  = '{0, 83, 0, 38};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 83, 38};

  typedef struct {
    logic signed [31:0]          part_x;
    logic signed [31:0]          part_y;
    logic signed [31:0]          part_z;
    logic signed [31:0]          orig_x;
    logic signed [31:0]          orig_y;
    logic signed [31:0]          orig_z;
    logic [hcrc_pkg::MASK_W-1:0] mask;
  } particle_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [hcrc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [hcrc_pkg::SIZE_W-1:0]    cfg_data_i;

  hcrc_in_if  in_ch ();
  hcrc_out_if out_ch ();

  halo_corner_region_classify_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Local copy of the cell extent registers.
  logic [hcrc_pkg::SIZE_W-1:0] cell_x;
  logic [hcrc_pkg::SIZE_W-1:0] cell_y;
  logic [hcrc_pkg::SIZE_W-1:0] cell_z;

  hcrc_pkg::result_t expected_results[$];
  int                error_count;
  int                mismatch_count;
  int unsigned       sender_idle_pct;
  int unsigned       sink_stall_pct;

  // Classify one particle the way the block must.
  function automatic hcrc_pkg::result_t predict_region(input particle_t p);
    hcrc_pkg::result_t res;
    longint            dx, dy, dz, dy2;
    logic              three, hit, outside;
    logic              fn, fs, fe, fw, fa, fb;
    hcrc_pkg::region_e face;
    three = (cell_z != '0);
    dx = longint'(p.part_x) - longint'(p.orig_x);
    dy = longint'(p.part_y) - longint'(p.orig_y);
    dz = three ? longint'(p.part_z) - longint'(p.orig_z) : 0;
    dy2 = 2 * dy;
    fn = p.mask[hcrc_pkg::MASK_NORTH];
    fs = p.mask[hcrc_pkg::MASK_SOUTH];
    fe = p.mask[hcrc_pkg::MASK_EAST];
    fw = p.mask[hcrc_pkg::MASK_WEST];
    fa = p.mask[hcrc_pkg::MASK_ABOVE];
    fb = p.mask[hcrc_pkg::MASK_BELOW];
    hit = 1'b1;
    face = hcrc_pkg::REGION_NORTH;

    if (!three) begin
      // Planar corner: split along the x/y diagonal.
      if (fn && fe) face = (dx <= dy) ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_EAST;
      else if (fs && fw) face = (dx <= dy) ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_SOUTH;
      else if (fn && fw) face = (dx > dy) ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_WEST;
      else if (fs && fe) face = (dx > dy) ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_SOUTH;
      else hit = 1'b0;
    end else if ($countones(p.mask) == 2) begin
      // Edge of a 3D cell: split along the diagonal of the two face axes.
      if (fn && fe) face = (dx <= dy) ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_EAST;
      else if (fs && fw) face = (dx <= dy) ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_SOUTH;
      else if (fn && fw) face = (dx > dy) ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_WEST;
      else if (fs && fe) face = (dx > dy) ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_SOUTH;
      else if (fb && fw) face = (dx <= dz) ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_BELOW;
      else if (fa && fe) face = (dx <= dz) ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_EAST;
      else if (fb && fe) face = (dx > dz) ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_BELOW;
      else if (fa && fw) face = (dx > dz) ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_WEST;
      else if (fb && fs) face = (dz <= dy) ? hcrc_pkg::REGION_BELOW : hcrc_pkg::REGION_SOUTH;
      else if (fa && fn) face = (dz <= dy) ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_ABOVE;
      else if (fb && fn) face = (dz > dy) ? hcrc_pkg::REGION_NORTH : hcrc_pkg::REGION_BELOW;
      else if (fa && fs) face = (dz > dy) ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_SOUTH;
      else hit = 1'b0;
    end else begin
      // Triple corner: doubled plane tests against absolute thresholds.
      if (fb && fs && fe)
        face = (dx - dz + dy2 >= UNIT)
             ? ((dx > dz) ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_BELOW)
             : hcrc_pkg::REGION_SOUTH;
      else if (fb && fs && fw)
        face = (-dx - dz + dy2 >= 0)
             ? ((dx <= dz) ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_BELOW)
             : hcrc_pkg::REGION_SOUTH;
      else if (fb && fn && fe)
        face = (-dx + dz + dy2 >= UNIT) ? hcrc_pkg::REGION_NORTH
             : ((dx > dz) ? hcrc_pkg::REGION_EAST : hcrc_pkg::REGION_BELOW);
      else if (fb && fn && fw)
        face = (dx + dz + dy2 >= 2 * UNIT) ? hcrc_pkg::REGION_NORTH
             : ((dx <= dz) ? hcrc_pkg::REGION_WEST : hcrc_pkg::REGION_BELOW);
      else if (fa && fs && fe)
        face = (dx + dz + dy2 >= 2 * UNIT)
             ? ((dx <= dz) ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_EAST)
             : hcrc_pkg::REGION_SOUTH;
      else if (fa && fs && fw)
        face = (-dx + dz + dy2 >= UNIT)
             ? ((dx > dz) ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_WEST)
             : hcrc_pkg::REGION_SOUTH;
      else if (fa && fn && fe)
        face = (-dx - dz + dy2 >= 0) ? hcrc_pkg::REGION_NORTH
             : ((dx <= dz) ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_EAST);
      else if (fa && fn && fw)
        face = (dx - dz + dy2 >= UNIT) ? hcrc_pkg::REGION_NORTH
             : ((dx > dz) ? hcrc_pkg::REGION_ABOVE : hcrc_pkg::REGION_WEST);
      else hit = 1'b0;
    end

    outside = (dx < 0) || (dx > longint'(cell_x)) || (dy < 0) || (dy > longint'(cell_y));
    if (three && ((dz < 0) || (dz > longint'(cell_z)))) outside = 1'b1;

    res.region        = hit ? face : hcrc_pkg::REGION_NORTH;
    res.fallback_used = !hit;
    res.outside_cell  = outside;
    return res;
  endfunction

  // Mostly corner, edge and triple-corner masks, the rest fully random.
  function automatic logic [hcrc_pkg::MASK_W-1:0] random_mask();
    logic [hcrc_pkg::MASK_W-1:0] ns, ew, ud, mask;
    ns = $urandom_range(0, 1) ? FACE_N : FACE_S;
    ew = $urandom_range(0, 1) ? FACE_E : FACE_W;
    ud = $urandom_range(0, 1) ? FACE_A : FACE_B;
    if ($urandom_range(0, 99) < 25) begin
      mask = hcrc_pkg::MASK_W'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0:       mask = ns | ew;
        1:       mask = ns | ud;
        2:       mask = ew | ud;
        default: mask = ns | ew | ud;
      endcase
    end
    return mask;
  endfunction

  // Offset within the cell extent plus a margin of an eighth on each side.
  function automatic longint span_offset(input logic [hcrc_pkg::SIZE_W-1:0] size);
    longint          s, margin;
    longint unsigned r;
    s = (size == '0) ? UNIT : longint'(size);
    margin = s >>> 3;
    r = {$urandom(), $urandom()};
    return longint'(r % longint'(s + 2 * margin + 1)) - margin;
  endfunction

  function automatic particle_t random_particle();
    particle_t   p;
    longint      rx, ry, rz, ox, oy, oz;
    int unsigned mode;
    mode = $urandom_range(0, 99);
    p.mask = random_mask();
    if (mode < 10) begin
      // Unrelated raw coordinates.
      p.part_x = $urandom();
      p.part_y = $urandom();
      p.part_z = $urandom();
      p.orig_x = $urandom();
      p.orig_y = $urandom();
      p.orig_z = $urandom();
    end else begin
      if (mode < 35) begin
        // Quarter-unit grid hits diagonal ties and plane thresholds exactly.
        rx = (longint'($urandom_range(0, 10)) - 1) * QUARTER;
        ry = (longint'($urandom_range(0, 10)) - 1) * QUARTER;
        rz = (longint'($urandom_range(0, 10)) - 1) * QUARTER;
      end else begin
        rx = span_offset(cell_x);
        ry = span_offset(cell_y);
        rz = span_offset(cell_z);
      end
      case ($urandom_range(0, 7))
        0:       ry = rx;
        1:       rz = rx;
        2:       rz = ry;
        default: ;
      endcase
      if ($urandom_range(0, 1)) begin
        ox = longint'($signed($urandom()));
        oy = longint'($signed($urandom()));
        oz = longint'($signed($urandom()));
      end else begin
        ox = longint'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
        oy = longint'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
        oz = longint'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
      end
      p.part_x = 32'(ox + rx);
      p.part_y = 32'(oy + ry);
      p.part_z = 32'(oz + rz);
      p.orig_x = 32'(ox);
      p.orig_y = 32'(oy);
      p.orig_z = 32'(oz);
    end
    return p;
  endfunction

  // Send one transaction and record its expected result once accepted.
  task automatic send_particle(input particle_t p);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.particle_x <= p.part_x;
    in_ch.particle_y <= p.part_y;
    in_ch.particle_z <= p.part_z;
    in_ch.origin_x   <= p.orig_x;
    in_ch.origin_y   <= p.orig_y;
    in_ch.origin_z   <= p.orig_z;
    in_ch.halo_mask  <= p.mask;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_results.push_back(predict_region(p));
  endtask

  // Directed transaction given relative to the fixed origin.
  task automatic send_rel(input longint rx, input longint ry, input longint rz,
                          input logic [hcrc_pkg::MASK_W-1:0] mask);
    particle_t p;
    p.orig_x = 32'(DIR_ORG_X);
    p.orig_y = 32'(DIR_ORG_Y);
    p.orig_z = 32'(DIR_ORG_Z);
    p.part_x = 32'(DIR_ORG_X + rx);
    p.part_y = 32'(DIR_ORG_Y + ry);
    p.part_z = 32'(DIR_ORG_Z + rz);
    p.mask   = mask;
    send_particle(p);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cell_size(input hcrc_pkg::cfg_idx_e idx,
                                 input logic [hcrc_pkg::SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      hcrc_pkg::CFG_SIZE_X: cell_x = value;
      hcrc_pkg::CFG_SIZE_Y: cell_y = value;
      hcrc_pkg::CFG_SIZE_Z: cell_z = value;
      default:    ;
    endcase
  endtask

  task automatic set_cell_sizes(input logic [hcrc_pkg::SIZE_W-1:0] sx,
                                input logic [hcrc_pkg::SIZE_W-1:0] sy,
                                input logic [hcrc_pkg::SIZE_W-1:0] sz);
    write_cell_size(hcrc_pkg::CFG_SIZE_X, sx);
    write_cell_size(hcrc_pkg::CFG_SIZE_Y, sy);
    write_cell_size(hcrc_pkg::CFG_SIZE_Z, sz);
  endtask

  // Reset sizes, 3D: edges, triple corners, fallbacks, outside and extreme coordinates.
  task automatic test_reset_sizes_3d();
    particle_t p;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    send_rel(QUARTER, 3 * QUARTER, 2 * QUARTER, FACE_N | FACE_E);
    send_rel(3 * QUARTER, QUARTER, 2 * QUARTER, FACE_N | FACE_E);
    send_rel(2 * QUARTER, 2 * QUARTER, QUARTER, FACE_S | FACE_W);
    send_rel(QUARTER, 3 * QUARTER, 2 * QUARTER, FACE_N | FACE_W);
    send_rel(QUARTER, 2 * QUARTER, 3 * QUARTER, FACE_A | FACE_E);
    send_rel(3 * QUARTER, 2 * QUARTER, QUARTER, FACE_B | FACE_E);
    send_rel(2 * QUARTER, QUARTER, 3 * QUARTER, FACE_B | FACE_S);
    send_rel(2 * QUARTER, 3 * QUARTER, 2 * QUARTER, FACE_B | FACE_N);
    send_rel(3 * QUARTER, QUARTER, QUARTER, FACE_B | FACE_S | FACE_E);
    send_rel(QUARTER, QUARTER, 2 * QUARTER, FACE_A | FACE_N | FACE_W);
    send_rel(2 * QUARTER, 2 * QUARTER, 2 * QUARTER, FACE_A | FACE_S | FACE_E);
    // Masks that match no case: one face, opposite faces, empty.
    send_rel(2 * QUARTER, 2 * QUARTER, 2 * QUARTER, FACE_N);
    send_rel(QUARTER, 2 * QUARTER, 3 * QUARTER, FACE_N | FACE_S);
    send_rel(QUARTER, QUARTER, QUARTER, '0);
    // Four and six faces go through the triple-corner priority.
    send_rel(QUARTER, QUARTER, QUARTER, FACE_N | FACE_S | FACE_E | FACE_B);
    send_rel(QUARTER, QUARTER, QUARTER, '1);
    // Outside the cell along x and along z, and the far corner inside.
    send_rel(-1, QUARTER, QUARTER, FACE_N | FACE_E);
    send_rel(QUARTER, QUARTER, UNIT + 1, FACE_S | FACE_W);
    send_rel(UNIT, UNIT, UNIT, FACE_A | FACE_N | FACE_E);
    // Extreme coordinates in both directions.
    p.part_x = 32'sh7FFFFFFF;
    p.part_y = 32'sh7FFFFFFF;
    p.part_z = 32'sh7FFFFFFF;
    p.orig_x = 32'sh80000000;
    p.orig_y = 32'sh80000000;
    p.orig_z = 32'sh80000000;
    p.mask   = '1;
    send_particle(p);
    p.part_x = 32'sh80000000;
    p.part_y = 32'sh80000000;
    p.part_z = 32'sh80000000;
    p.orig_x = 32'sh7FFFFFFF;
    p.orig_y = 32'sh7FFFFFFF;
    p.orig_z = 32'sh7FFFFFFF;
    p.mask   = FACE_B | FACE_N | FACE_W;
    send_particle(p);
    drain_results();
  endtask

  // Zero depth selects planar handling; vertical bits and z are ignored.
  task automatic test_directed_2d();
    set_cell_sizes(SIZE_ONE, SIZE_ONE, SIZE_ZERO);
    sender_idle_pct = 38;
    sink_stall_pct  = 38;
    send_rel(QUARTER, 3 * QUARTER, QUARTER, FACE_N | FACE_E);
    send_rel(3 * QUARTER, QUARTER, QUARTER, FACE_S | FACE_W);
    send_rel(3 * QUARTER, QUARTER, -5 * UNIT, FACE_N | FACE_W);
    send_rel(QUARTER, 3 * QUARTER, QUARTER, FACE_S | FACE_E);
    send_rel(2 * QUARTER, 2 * QUARTER, 0, FACE_N | FACE_E | FACE_A | FACE_B);
    send_rel(QUARTER, QUARTER, 0, FACE_A | FACE_B);
    send_rel(QUARTER, QUARTER, 0, FACE_N | FACE_S);
    send_rel(UNIT + 1, QUARTER, 0, FACE_S | FACE_E);
    drain_results();
  endtask

  // Random traffic over several cell settings and idling patterns.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_cell_sizes(SIZE_ONE, SIZE_ONE, SIZE_ONE);
        1: set_cell_sizes(SIZE_ONE, SIZE_ONE, SIZE_ZERO);
        2: set_cell_sizes(SIZE_MAX, SIZE_MAX, SIZE_MAX);
        3: set_cell_sizes(SIZE_ZERO, SIZE_ZERO, SIZE_ZERO);
        4: set_cell_sizes(hcrc_pkg::SIZE_W'($urandom_range(1, 4 * UNIT)),
                          hcrc_pkg::SIZE_W'($urandom_range(1, 4 * UNIT)),
                          hcrc_pkg::SIZE_W'($urandom_range(1, 4 * UNIT)));
        5: set_cell_sizes(hcrc_pkg::SIZE_W'($urandom_range(1, 4 * UNIT)),
                          hcrc_pkg::SIZE_W'($urandom_range(1, 4 * UNIT)), SIZE_ZERO);
        6: set_cell_sizes(hcrc_pkg::SIZE_W'($urandom()), hcrc_pkg::SIZE_W'($urandom()),
                          hcrc_pkg::SIZE_W'($urandom()));
        default: set_cell_sizes(hcrc_pkg::SIZE_W'(2 * UNIT), hcrc_pkg::SIZE_W'(UNIT / 2),
                                SIZE_ONE);
      endcase
      sender_idle_pct = SEND_IDLE[phase % 4];
      sink_stall_pct  = RECV_STALL[phase % 4];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold the sender until the block has emptied, midway through the phase.
        if (n == ITEMS_PER_PHASE / 2) drain_results();
        send_particle(random_particle());
      end
      drain_results();
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver readiness, redrawn every cycle.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    hcrc_pkg::result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (mismatch_count < MAX_REPORTS)
          $display("Unexpected result: region %0d fallback %0b outside %0b",
                   out_ch.region, out_ch.fallback_used, out_ch.outside_cell);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.region !== want.region || out_ch.fallback_used !== want.fallback_used ||
            out_ch.outside_cell !== want.outside_cell) begin
          error_count++;
          if (mismatch_count < MAX_REPORTS)
            $display("Mismatch: expected region %0d fallback %0b outside %0b, %s %0d %0b %0b",
                     want.region, want.fallback_used, want.outside_cell, "got",
                     out_ch.region, out_ch.fallback_used, out_ch.outside_cell);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Test sequence.
  initial begin
    error_count      = 0;
    mismatch_count   = 0;
    sender_idle_pct  = 0;
    sink_stall_pct   = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = hcrc_pkg::CFG_SIZE_X;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.particle_x = '0;
    in_ch.particle_y = '0;
    in_ch.particle_z = '0;
    in_ch.origin_x   = '0;
    in_ch.origin_y   = '0;
    in_ch.origin_z   = '0;
    in_ch.halo_mask  = '0;
    cell_x           = hcrc_pkg::SIZE_RESET;
    cell_y           = hcrc_pkg::SIZE_RESET;
    cell_z           = hcrc_pkg::SIZE_RESET;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_sizes_3d();
    test_directed_2d();
    test_random_traffic();
    drain_results();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
